// ===== rtl/ibds_pkg.sv =====
`default_nettype none
package ibds_pkg;

  localparam int CLK_W   = 28;
  localparam int BAUD_W  = 20;
  localparam int CODE_W  = 8;
  localparam int ERR_W   = 34;
  localparam int IDX_W   = 6;
  localparam int MIDX_W  = 2;
  localparam int DIV_W   = 12;
  localparam int PROD_W  = DIV_W + BAUD_W;
  localparam int TAB_N   = 64;

  localparam logic [MIDX_W-1:0] MULT_LAST = 2'd2;

  localparam logic [DIV_W-1:0] DIV_TAB [TAB_N] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
    12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
    12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
    12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
    12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
    12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
    12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
    12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd2840
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              capture;
    logic              issue;
    logic              first;
    logic              last;
    logic [MIDX_W-1:0] mult_idx;
    logic [IDX_W-1:0]  div_idx;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/ibds_if.sv =====
`default_nettype none
interface ibds_in_if;
  logic                          valid;
  logic                          ready;
  logic [ibds_pkg::CLK_W-1:0]    bus_clock_hz;
  logic [ibds_pkg::BAUD_W-1:0]   target_baud;

  modport source (output valid, output bus_clock_hz, output target_baud, input ready);
  modport sink   (input valid, input bus_clock_hz, input target_baud, output ready);
endinterface

interface ibds_out_if;
  logic                          valid;
  logic                          ready;
  logic [ibds_pkg::CODE_W-1:0]   divider_code;
  logic [ibds_pkg::ERR_W-1:0]    best_error;

  modport source (output valid, output divider_code, output best_error, input ready);
  modport sink   (input valid, input divider_code, input best_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2c_baud_divider_search.sv =====
// I2C baud divider search.
// in_ch carries a request: bus clock in hertz and a target bit rate. out_ch
// returns the 8-bit divider code (multiplier index in 7:6, divider index in
// 5:0) and the absolute error of the best candidate; first minimum wins.
// Both channels use valid/ready; a transfer happens when both are high.
// One request is searched at a time: a controller steps through
// 3 * DIVIDER_ENTRIES candidates, one per cycle through a single 12x20
// multiplier, a difference stage and a compare stage. A new request is
// taken in the cycle after the result is loaded; requests do not overlap.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver still holds off when the next search ends, the
// block waits with that result until the register frees.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out valid; no request in flight survives.
`default_nettype none
module i2c_baud_divider_search #(
  parameter int DIVIDER_ENTRIES = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ibds_in_if.sink     in_ch,
  ibds_out_if.source  out_ch
);
  import ibds_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  ibds_ctrl #(
    .DIVIDER_ENTRIES(DIVIDER_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  ibds_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_clk_hz (in_ch.bus_clock_hz),
    .in_baud   (in_ch.target_baud),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_code  (out_ch.divider_code),
    .out_err   (out_ch.best_error)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

// ===== rtl/ibds_ctrl.sv =====
`default_nettype none
module ibds_ctrl #(
  parameter int DIVIDER_ENTRIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output ibds_pkg::cmd_t         cmd,
  input  wire ibds_pkg::status_t status
);
  import ibds_pkg::*;

  localparam logic [IDX_W-1:0] DIV_LAST = IDX_W'(DIVIDER_ENTRIES - 1);

  state_t            state_r, state_nxt;
  logic [MIDX_W-1:0] mult_r, mult_nxt;
  logic [IDX_W-1:0]  div_r, div_nxt;
  logic              last_cand;

  assign last_cand = (mult_r == MULT_LAST) && (div_r == DIV_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_RUN;
      ST_RUN:    if (last_cand) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (status.search_done) state_nxt = ST_FINISH;
      ST_FINISH: if (!status.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mult_idx = mult_r;
    cmd.div_idx  = div_r;
    cmd.first    = (mult_r == '0) && (div_r == '0);
    cmd.last     = last_cand;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_RUN:    cmd.issue    = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: cmd.load_out = !status.out_busy;
      default:   ;
    endcase
  end

  always_comb begin
    mult_nxt = mult_r;
    div_nxt  = div_r;
    if (state_r == ST_IDLE) begin
      mult_nxt = '0;
      div_nxt  = '0;
    end else if (state_r == ST_RUN && !last_cand) begin
      if (div_r == DIV_LAST) begin
        div_nxt  = '0;
        mult_nxt = mult_r + 1'b1;
      end else begin
        div_nxt = div_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mult_r  <= '0;
      div_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mult_r  <= mult_nxt;
      div_r   <= div_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ibds_dp.sv =====
`default_nettype none
module ibds_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ibds_pkg::cmd_t             cmd,
  output ibds_pkg::status_t               status,
  input  wire logic [ibds_pkg::CLK_W-1:0] in_clk_hz,
  input  wire logic [ibds_pkg::BAUD_W-1:0] in_baud,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [ibds_pkg::CODE_W-1:0]     out_code,
  output logic [ibds_pkg::ERR_W-1:0]      out_err
);
  import ibds_pkg::*;

  typedef struct packed {
    logic              first;
    logic              last;
    logic [MIDX_W-1:0] mult_idx;
    logic [IDX_W-1:0]  div_idx;
  } tag_t;

  logic [CLK_W-1:0]  clk_hz_r;
  logic [BAUD_W-1:0] baud_r;

  logic              s1_vld_r, s2_vld_r;
  tag_t              s1_tag_r, s2_tag_r;
  logic [ERR_W-1:0]  prod_r, err_r;
  logic [PROD_W-1:0] prod_raw;
  logic [ERR_W-1:0]  prod_nxt, err_nxt, clk_ext;

  logic [ERR_W-1:0]  best_err_r;
  logic [CODE_W-1:0] best_code_r;
  logic              done_r;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic [ERR_W-1:0]  out_err_r;

  assign prod_raw = DIV_TAB[cmd.div_idx] * PROD_W'(baud_r);
  assign prod_nxt = ERR_W'(prod_raw) << cmd.mult_idx;
  assign clk_ext  = ERR_W'(clk_hz_r);
  assign err_nxt  = (prod_r >= clk_ext) ? (prod_r - clk_ext) : (clk_ext - prod_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      clk_hz_r <= in_clk_hz;
      baud_r   <= in_baud;
    end
    prod_r   <= prod_nxt;
    s1_tag_r <= '{first: cmd.first, last: cmd.last, mult_idx: cmd.mult_idx,
                  div_idx: cmd.div_idx};
    err_r    <= err_nxt;
    s2_tag_r <= s1_tag_r;
    if (s2_vld_r && (s2_tag_r.first || err_r < best_err_r)) begin
      best_err_r  <= err_r;
      best_code_r <= {s2_tag_r.mult_idx, s2_tag_r.div_idx};
    end
    if (cmd.load_out) begin
      out_code_r <= best_code_r;
      out_err_r  <= best_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
      if (cmd.capture) begin
        done_r <= 1'b0;
      end else if (s2_vld_r && s2_tag_r.last) begin
        done_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.search_done = done_r;
  assign status.out_busy    = out_valid_r && !out_ready;
  assign out_valid          = out_valid_r;
  assign out_code           = out_code_r;
  assign out_err            = out_err_r;

endmodule
`default_nettype wire
